// ===== sv/ppp_pkg.sv =====
package ppp_pkg;

	// offset = col + y * line_bytes reaches 511 + 255 * 255, which needs 17 bits
	localparam int OFF_W = 17;
	// page quotient bits: FRAME_BYTES / PAGE_BYTES never exceeds 64 pages
	localparam int QUO_W = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [5:0]  FIRST_PAGE  = 6'h30;
	localparam logic [13:0] WINDOW_BASE = 14'h2000;

	localparam logic [CFG_IDX_W-1:0] REG_FOUR_COLOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 1'd1;

	localparam logic [7:0] LINE_BYTES_RESET = 8'd160;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [7:0] pixel_y;
		logic [3:0] color;
	} pix_in_t;

	typedef struct packed {
		logic        dropped;
		logic [5:0]  page_number;
		logic [13:0] window_address;
		logic [7:0]  new_byte;
	} pix_out_t;

	typedef struct packed {
		logic clear_en;
		logic capture;
		logic calc_offset;
		logic div_init;
		logic div_step;
		logic write_back;
		logic post_drop;
	} ppp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic oob;
		logic div_last;
	} ppp_sts_t;

endpackage

// ===== sv/ppp_ctrl.sv =====
module ppp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ppp_pkg::ppp_sts_t sts,
	output ppp_pkg::ppp_cmd_t cmd,
	output logic            busy
);
	import ppp_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OFFSET,
		ST_CHECK,
		ST_DIV,
		ST_WRITE
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_OFFSET;
						busy_q  <= 1'b1;
					end
				end
				ST_OFFSET: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.oob) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.clear_en    = (state_q == ST_CLEAR);
		cmd.capture     = (state_q == ST_IDLE) && start;
		cmd.calc_offset = (state_q == ST_OFFSET);
		cmd.div_init    = (state_q == ST_CHECK) && !sts.oob;
		cmd.post_drop   = (state_q == ST_CHECK) && sts.oob;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.write_back  = (state_q == ST_WRITE);
	end

	assign busy = busy_q;

endmodule

// ===== sv/ppp_datapath.sv =====
module ppp_datapath #(
	parameter int FRAME_BYTES = 32768,
	parameter int PAGE_BYTES  = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppp_pkg::ppp_cmd_t               cmd,
	output ppp_pkg::ppp_sts_t               sts,
	input  ppp_pkg::pix_in_t                pixel,
	input  logic                            cfg_we,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data,
	output logic                            done,
	output ppp_pkg::pix_out_t               result
);
	import ppp_pkg::*;

	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int RCP_W  = 8;
	// page reciprocal scaled by 2^OFF_W; the quotient estimate is exact or one low
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << OFF_W) / PAGE_BYTES);
	localparam logic [OFF_W-1:0] PAGE_OFF = OFF_W'(PAGE_BYTES);
	localparam logic [OFF_W-1:0] FRAME_LIM = OFF_W'(FRAME_BYTES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);

	logic [7:0] store [FRAME_BYTES];

	logic             four_color_q;
	logic [7:0]       line_bytes_q;
	pix_in_t          pix_q;
	logic [OFF_W-1:0] offset_q;
	logic [ADDR_W-1:0] clear_q;
	logic [OFF_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             step_q;
	logic [7:0]       rd_q;
	pix_out_t         result_q;
	logic             done_q;

	logic [8:0]       col;
	logic [15:0]      prod;
	logic [OFF_W+RCP_W-1:0] recip_prod;
	logic [OFF_W-1:0] page_base;
	logic             fits;
	logic [7:0]       merged;
	logic [2:0]       shift;
	logic [7:0]       mask;
	logic [7:0]       ins;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_color_q <= 1'b0;
			line_bytes_q <= LINE_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOUR_COLOR: four_color_q <= cfg_data[0];
				REG_LINE_BYTES: line_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign col  = four_color_q ? {1'b0, pix_q.pixel_x[9:2]} : pix_q.pixel_x[9:1];
	assign prod = {8'd0, pix_q.pixel_y} * {8'd0, line_bytes_q};

	assign recip_prod = {{RCP_W{1'b0}}, offset_q} * {{OFF_W{1'b0}}, RECIP};
	assign page_base  = OFF_W'(quo_q) * PAGE_OFF;
	assign fits       = rem_q >= PAGE_OFF;

	// leftmost pixel sits in the high bits
	always_comb begin
		if (four_color_q) begin
			shift = {~pix_q.pixel_x[1:0], 1'b0};
			mask  = 8'h03 << shift;
			ins   = {6'd0, pix_q.color[1:0]} << shift;
		end else begin
			shift = pix_q.pixel_x[0] ? 3'd0 : 3'd4;
			mask  = 8'h0F << shift;
			ins   = {4'd0, pix_q.color} << shift;
		end
		merged = (rd_q & ~mask) | ins;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) pix_q <= pixel;
		if (cmd.calc_offset) offset_q <= OFF_W'(col) + OFF_W'(prod);
		if (cmd.div_init) begin
			rem_q  <= offset_q;
			quo_q  <= recip_prod[OFF_W +: QUO_W];
			step_q <= 1'b1;
		end else if (cmd.div_step) begin
			// first step: subtract the estimated page base; second: bump a low estimate
			if (step_q) begin
				rem_q <= rem_q - page_base;
			end else if (fits) begin
				rem_q <= rem_q - PAGE_OFF;
				quo_q <= quo_q + 1'b1;
			end
			step_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= '0;
		end else if (cmd.clear_en) begin
			clear_q <= clear_q + 1'b1;
		end
	end

	assign wr_en   = cmd.clear_en || cmd.write_back;
	assign wr_addr = cmd.clear_en ? clear_q : offset_q[ADDR_W-1:0];
	assign wr_data = cmd.clear_en ? 8'd0 : merged;

	always_ff @(posedge clk) begin
		if (wr_en) store[wr_addr] <= wr_data;
		if (cmd.div_init) rd_q <= store[offset_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.post_drop) begin
			result_q <= '{dropped: 1'b1, page_number: '0, window_address: '0, new_byte: '0};
		end else if (cmd.write_back) begin
			result_q.dropped        <= 1'b0;
			result_q.page_number    <= FIRST_PAGE + quo_q;
			result_q.window_address <= WINDOW_BASE + rem_q[13:0];
			result_q.new_byte       <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cmd.post_drop || cmd.write_back;
	end

	assign sts.clear_last = (clear_q == LAST_ADDR);
	assign sts.oob        = (offset_q >= FRAME_LIM);
	assign sts.div_last   = !step_q;

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/packed_pixel_plot_banked.sv =====
// Channel   Direction  Handshake               Payload
// command   in         start, taken when !busy pixel  (pix_in_t: pixel_x, pixel_y, color)
// result    out        done, one-cycle strobe  result (pix_out_t: dropped, page_number,
//                                                      window_address, new_byte)
// config    in         cfg_we, no wait         cfg_index, cfg_data
//
// After reset the frame store is swept to zero, one byte a cycle, with busy held high
// until the sweep ends. A plot beat holds busy high after it is taken, through its steps:
// offset, bounds check with the store read and a reciprocal page estimate, remainder,
// a one-step quotient correction, then the write back. A dropped beat ends at the check.
// done pulses the cycle after the last step; the receiver cannot stall,
// and a new start is taken while that result is on the ports.
module packed_pixel_plot_banked #(
	parameter int FRAME_BYTES = 32768,
	parameter int PAGE_BYTES  = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ppp_pkg::pix_in_t              pixel,
	output logic                          done,
	output ppp_pkg::pix_out_t             result,
	input  logic                          cfg_we,
	input  logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import ppp_pkg::*;

	// command and status between sequencer and datapath
	ppp_cmd_t cmd;
	ppp_sts_t sts;

	// sequence: clear sweep, then offset, check, divide, write back per beat
	ppp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the store, the config registers, the divider and the result register
	ppp_datapath #(
		.FRAME_BYTES (FRAME_BYTES),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule
